// ===== src/serial_frame_deframer_defines.svh =====
// assertion macros for the serial frame deframer
// used by the top level only, needs aclk and aresetn in scope
`ifndef SERIAL_FRAME_DEFRAMER_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_DEFINES_SVH

// condition holds in the same cycle
`define SFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("serial_frame_deframer: assertion failed");

// condition holds in the next cycle
`define SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("serial_frame_deframer: assertion failed");

`endif

// ===== src/sfd_pkg.sv =====
// shared constants and controller/datapath interface types
// no dependencies
package sfd_pkg;

    localparam int MAX_PAYLOAD = 59;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HDR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HDR = 1'd1;

    localparam logic [BYTE_W-1:0] FIRST_HDR_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_HDR_RST = 8'h55;

    typedef struct packed {
        logic cap_type;
        logic cap_len;
        logic wr_data;
        logic start_drain;
        logic drain_en;
    } sfd_cmd_t;

    typedef struct packed {
        logic hdr1_hit;
        logic hdr2_hit;
        logic len_bad;
        logic len_zero;
        logic fill_done;
        logic sum_ok;
        logic drain_last;
    } sfd_sts_t;

endpackage

// ===== src/sfd_ctrl.sv =====
// parse and drain state machine of the serial frame deframer
// depends on sfd_pkg, drives sfd_datapath through command and status structs
module sfd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sfd_pkg::sfd_sts_t sts,
    output sfd_pkg::sfd_cmd_t cmd
);

    localparam logic [2:0] ST_HEAD1 = 3'd0;
    localparam logic [2:0] ST_HEAD2 = 3'd1;
    localparam logic [2:0] ST_TYPE  = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_CHECK = 3'd5;
    localparam logic [2:0] ST_DRAIN = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b1;
        unique case (state_reg)
            ST_HEAD2: begin
                if (accept) begin
                    state_next = sts.hdr2_hit ? ST_TYPE : ST_HEAD1;
                end
            end
            ST_TYPE: begin
                if (accept) begin
                    cmd.cap_type = 1'b1;
                    state_next   = ST_LEN;
                end
            end
            ST_LEN: begin
                if (accept) begin
                    if (sts.len_bad) begin
                        state_next = ST_HEAD1;
                    end else begin
                        cmd.cap_len = 1'b1;
                        state_next  = sts.len_zero ? ST_CHECK : ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (accept) begin
                    cmd.wr_data = 1'b1;
                    if (sts.fill_done) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (accept) begin
                    if (sts.sum_ok) begin
                        cmd.start_drain = 1'b1;
                        state_next      = ST_DRAIN;
                    end else begin
                        state_next = ST_HEAD1;
                    end
                end
            end
            ST_DRAIN: begin
                s_ready      = 1'b0;
                cmd.drain_en = 1'b1;
                if (sts.drain_last) begin
                    state_next = ST_HEAD1;
                end
            end
            // hunting the first header byte, unused code acts the same
            default: begin
                if (accept) begin
                    state_next = sts.hdr1_hit ? ST_HEAD2 : ST_HEAD1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HEAD1;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/sfd_datapath.sv =====
// header registers, frame fields, checksum, payload buffer and output pipeline
// depends on sfd_pkg, controlled by sfd_ctrl
module sfd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]          cfg_wdata,
    input  logic [sfd_pkg::BYTE_W-1:0]          rx_byte,
    input  sfd_pkg::sfd_cmd_t                   cmd,
    output sfd_pkg::sfd_sts_t                   sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sfd_pkg::BYTE_W-1:0]          m_pkt_type,
    output logic [sfd_pkg::LEN_W-1:0]           m_frame_length,
    output logic [sfd_pkg::LEN_W-1:0]           m_byte_index,
    output logic [sfd_pkg::BYTE_W-1:0]          m_payload_byte,
    output logic                                m_last_of_frame
);

    logic [sfd_pkg::BYTE_W-1:0] first_hdr_reg, first_hdr_next;
    logic [sfd_pkg::BYTE_W-1:0] second_hdr_reg, second_hdr_next;
    logic [sfd_pkg::BYTE_W-1:0] held_type_reg, held_type_next;
    logic [sfd_pkg::LEN_W-1:0]  held_length_reg, held_length_next;
    logic [sfd_pkg::LEN_W-1:0]  fill_count_reg, fill_count_next;
    logic [sfd_pkg::BYTE_W-1:0] running_sum_reg, running_sum_next;
    logic [sfd_pkg::LEN_W-1:0]  rd_idx_reg, rd_idx_next;

    logic                       p1_valid_reg, p1_valid_next;
    logic [sfd_pkg::LEN_W-1:0]  p1_idx_reg, p1_idx_next;
    logic                       p1_last_reg, p1_last_next;
    logic                       p1_zero_reg, p1_zero_next;
    logic [sfd_pkg::BYTE_W-1:0] p1_type_reg, p1_type_next;
    logic [sfd_pkg::LEN_W-1:0]  p1_len_reg, p1_len_next;

    logic                       out_valid_reg, out_valid_next;
    logic [sfd_pkg::BYTE_W-1:0] out_type_reg, out_type_next;
    logic [sfd_pkg::LEN_W-1:0]  out_len_reg, out_len_next;
    logic [sfd_pkg::LEN_W-1:0]  out_idx_reg, out_idx_next;
    logic [sfd_pkg::BYTE_W-1:0] out_data_reg, out_data_next;
    logic                       out_last_reg, out_last_next;

    logic [sfd_pkg::BYTE_W-1:0] rd_data_reg;
    logic [sfd_pkg::BYTE_W-1:0] payload_mem [sfd_pkg::MAX_PAYLOAD];

    logic out_free;
    logic issue;
    logic is_last;
    logic fill_ok;

    assign out_free = !out_valid_reg || m_ready;
    assign issue    = cmd.drain_en && (!p1_valid_reg || out_free);
    assign is_last  = (held_length_reg == '0)
                   || ((7'(rd_idx_reg) + 7'd1) == 7'(held_length_reg));
    assign fill_ok  = 7'(fill_count_reg) < 7'(sfd_pkg::MAX_PAYLOAD);

    always_comb begin
        sts            = '0;
        sts.hdr1_hit   = rx_byte == first_hdr_reg;
        sts.hdr2_hit   = rx_byte == second_hdr_reg;
        sts.len_bad    = rx_byte > 8'(sfd_pkg::MAX_PAYLOAD);
        sts.len_zero   = rx_byte == '0;
        sts.fill_done  = (7'(fill_count_reg) + 7'(fill_ok)) >= 7'(held_length_reg);
        sts.sum_ok     = running_sum_reg == rx_byte;
        sts.drain_last = issue && is_last;
    end

    always_comb begin
        first_hdr_next   = first_hdr_reg;
        second_hdr_next  = second_hdr_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        fill_count_next  = fill_count_reg;
        running_sum_next = running_sum_reg;
        rd_idx_next      = rd_idx_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                sfd_pkg::REG_FIRST_HDR:  first_hdr_next  = cfg_wdata;
                sfd_pkg::REG_SECOND_HDR: second_hdr_next = cfg_wdata;
                default: ;
            endcase
        end

        if (cmd.cap_type) begin
            held_type_next   = rx_byte;
            running_sum_next = rx_byte;
        end
        if (cmd.cap_len) begin
            held_length_next = rx_byte[sfd_pkg::LEN_W-1:0];
            fill_count_next  = '0;
        end
        if (cmd.wr_data) begin
            running_sum_next = running_sum_reg + rx_byte;
            if (fill_ok) begin
                fill_count_next = fill_count_reg + 1'b1;
            end
        end
        if (cmd.start_drain) begin
            rd_idx_next = '0;
        end else if (issue) begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        p1_idx_next   = p1_idx_reg;
        p1_last_next  = p1_last_reg;
        p1_zero_next  = p1_zero_reg;
        p1_type_next  = p1_type_reg;
        p1_len_next   = p1_len_reg;
        if (issue) begin
            p1_valid_next = 1'b1;
            p1_idx_next   = rd_idx_reg;
            p1_last_next  = is_last;
            p1_zero_next  = held_length_reg == '0;
            p1_type_next  = held_type_reg;
            p1_len_next   = held_length_reg;
        end else if (out_free) begin
            p1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_type_next  = out_type_reg;
        out_len_next   = out_len_reg;
        out_idx_next   = out_idx_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (out_free) begin
            out_valid_next = p1_valid_reg;
            out_type_next  = p1_type_reg;
            out_len_next   = p1_len_reg;
            out_idx_next   = p1_idx_reg;
            out_data_next  = p1_zero_reg ? '0 : rd_data_reg;
            out_last_next  = p1_last_reg;
        end
    end

    // payload buffer, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.wr_data && fill_ok) begin
            payload_mem[fill_count_reg[sfd_pkg::ADDR_W-1:0]] <= rx_byte;
        end
        if (issue) begin
            rd_data_reg <= payload_mem[rd_idx_reg[sfd_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_hdr_reg   <= sfd_pkg::FIRST_HDR_RST;
            second_hdr_reg  <= sfd_pkg::SECOND_HDR_RST;
            held_type_reg   <= '0;
            held_length_reg <= '0;
            fill_count_reg  <= '0;
            running_sum_reg <= '0;
            rd_idx_reg      <= '0;
            p1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            first_hdr_reg   <= first_hdr_next;
            second_hdr_reg  <= second_hdr_next;
            held_type_reg   <= held_type_next;
            held_length_reg <= held_length_next;
            fill_count_reg  <= fill_count_next;
            running_sum_reg <= running_sum_next;
            rd_idx_reg      <= rd_idx_next;
            p1_valid_reg    <= p1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_idx_reg   <= p1_idx_next;
        p1_last_reg  <= p1_last_next;
        p1_zero_reg  <= p1_zero_next;
        p1_type_reg  <= p1_type_next;
        p1_len_reg   <= p1_len_next;
        out_type_reg <= out_type_next;
        out_len_reg  <= out_len_next;
        out_idx_reg  <= out_idx_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_pkt_type      = out_type_reg;
    assign m_frame_length  = out_len_reg;
    assign m_byte_index    = out_idx_reg;
    assign m_payload_byte  = out_data_reg;
    assign m_last_of_frame = out_last_reg;

endmodule

// ===== src/serial_frame_deframer.sv =====
// channel    dir  signals                                          beat
// s_         in   s_valid s_ready s_rx_byte                        one received byte
// m_         out  m_valid m_ready m_pkt_type m_frame_length        one payload byte
//                 m_byte_index m_payload_byte m_last_of_frame
// cfg_       in   cfg_valid cfg_ready cfg_index cfg_wdata          one header register write
//
// s_ready stays high while parsing, so each received byte is taken as soon as it is valid
// a good checksum starts a drain from the payload buffer, one result per cycle while the
// output is not stalled, through a registered read and an output register; s_ready stays low
// for the whole drain of max(n,1) results for a frame of n bytes; the buffer read port sets that pace
// synchronous active-low reset, headers return to 0xaa and 0x55, no clearing pass
// top level of the deframer, depends on sfd_pkg, sfd_ctrl, sfd_datapath and the defines header
`include "serial_frame_deframer_defines.svh"

module serial_frame_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sfd_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sfd_pkg::BYTE_W-1:0]    m_pkt_type,
    output logic [sfd_pkg::LEN_W-1:0]     m_frame_length,
    output logic [sfd_pkg::LEN_W-1:0]     m_byte_index,
    output logic [sfd_pkg::BYTE_W-1:0]    m_payload_byte,
    output logic                          m_last_of_frame,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]    cfg_wdata
);

    sfd_pkg::sfd_cmd_t cmd;
    sfd_pkg::sfd_sts_t sts;

    logic idx_ends_frame;
    logic idx_inside_frame;

    assign cfg_ready = 1'b1;

    sfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sfd_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .rx_byte         (s_rx_byte),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pkt_type      (m_pkt_type),
        .m_frame_length  (m_frame_length),
        .m_byte_index    (m_byte_index),
        .m_payload_byte  (m_payload_byte),
        .m_last_of_frame (m_last_of_frame)
    );

    assign idx_ends_frame   = (m_frame_length == '0 && m_byte_index == '0)
                           || (7'(m_byte_index) + 7'd1 == 7'(m_frame_length));
    assign idx_inside_frame = 7'(m_byte_index) + 7'd1 < 7'(m_frame_length);

    `SFD_ASSERT_SAME(a_drain_blocks_input, cmd.drain_en, !s_ready)
    `SFD_ASSERT_SAME(a_last_at_end, m_valid && m_last_of_frame, idx_ends_frame)
    `SFD_ASSERT_SAME(a_not_last_inside, m_valid && !m_last_of_frame, idx_inside_frame)
    `SFD_ASSERT_NEXT(a_drain_ends_free, sts.drain_last, s_ready)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// self-checking bench for serial_frame_deframer: received bytes in, payload beats out
// a local frame parser predicts every beat, checked in order; needs sfd_pkg and the rtl
module testbench;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 16;

    typedef enum logic [2:0] {
        HUNT_FIRST, HUNT_SECOND, TAKE_TYPE, TAKE_LENGTH, TAKE_PAYLOAD, TAKE_CHECKSUM
    } parse_phase_t;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

    typedef struct packed {
        logic [sfd_pkg::BYTE_W-1:0] pkt_type;
        logic [sfd_pkg::LEN_W-1:0]  frame_length;
        logic [sfd_pkg::LEN_W-1:0]  byte_index;
        logic [sfd_pkg::BYTE_W-1:0] payload_byte;
        logic                       last_of_frame;
    } payload_beat_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic [sfd_pkg::BYTE_W-1:0]    s_rx_byte = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic [sfd_pkg::BYTE_W-1:0]    m_pkt_type;
    logic [sfd_pkg::LEN_W-1:0]     m_frame_length;
    logic [sfd_pkg::LEN_W-1:0]     m_byte_index;
    logic [sfd_pkg::BYTE_W-1:0]    m_payload_byte;
    logic                          m_last_of_frame;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sfd_pkg::BYTE_W-1:0]    cfg_wdata = '0;

    // parser copy and header copy
    logic [sfd_pkg::BYTE_W-1:0] hdr_first;
    logic [sfd_pkg::BYTE_W-1:0] hdr_second;
    parse_phase_t               phase;
    logic [sfd_pkg::BYTE_W-1:0] held_type;
    logic [sfd_pkg::LEN_W-1:0]  held_len;
    int                         fill_count;
    logic [sfd_pkg::BYTE_W-1:0] running_sum;
    logic [sfd_pkg::BYTE_W-1:0] frame_buf [sfd_pkg::MAX_PAYLOAD];

    payload_beat_t pending_beats [$];

    int  cycle_count   = 0;
    int  errors        = 0;
    int  bytes_sent    = 0;
    int  frames_good   = 0;
    int  beats_checked = 0;
    int  header_writes = 0;
    int  hold_left     = 0;
    int  ready_stall   = 0;
    bit  steady        = 1'b0;

    serial_frame_deframer u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pkt_type      (m_pkt_type),
        .m_frame_length  (m_frame_length),
        .m_byte_index    (m_byte_index),
        .m_payload_byte  (m_payload_byte),
        .m_last_of_frame (m_last_of_frame),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("serial_frame_deframer test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 48);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 85)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, sfd_pkg::MAX_PAYLOAD - 1);
        return sfd_pkg::MAX_PAYLOAD;
    endfunction

    task automatic reset_parser();
        hdr_first   = sfd_pkg::FIRST_HDR_RST;
        hdr_second  = sfd_pkg::SECOND_HDR_RST;
        phase       = HUNT_FIRST;
        held_type   = '0;
        held_len    = '0;
        fill_count  = 0;
        running_sum = '0;
    endtask

    task automatic parse_rx_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
        payload_beat_t beat;
        int i;
        case (phase)
            HUNT_SECOND: begin
                phase = (b == hdr_second) ? TAKE_TYPE : HUNT_FIRST;
            end
            TAKE_TYPE: begin
                held_type   = b;
                running_sum = b;
                phase       = TAKE_LENGTH;
            end
            TAKE_LENGTH: begin
                if (b > 8'(sfd_pkg::MAX_PAYLOAD)) begin
                    phase = HUNT_FIRST;
                end else begin
                    held_len   = b[sfd_pkg::LEN_W-1:0];
                    fill_count = 0;
                    phase      = (b == 0) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD: begin
                if (fill_count < sfd_pkg::MAX_PAYLOAD) begin
                    frame_buf[fill_count] = b;
                    fill_count++;
                end
                running_sum = running_sum + b;
                if (fill_count >= held_len)
                    phase = TAKE_CHECKSUM;
            end
            TAKE_CHECKSUM: begin
                if (running_sum == b) begin
                    frames_good++;
                    beat.pkt_type     = held_type;
                    beat.frame_length = held_len;
                    if (held_len == 0) begin
                        beat.byte_index    = '0;
                        beat.payload_byte  = '0;
                        beat.last_of_frame = 1'b1;
                        pending_beats.push_back(beat);
                    end else begin
                        for (i = 0; i < held_len; i++) begin
                            beat.byte_index    = i[sfd_pkg::LEN_W-1:0];
                            beat.payload_byte  = frame_buf[i];
                            beat.last_of_frame = (i + 1 == held_len);
                            pending_beats.push_back(beat);
                        end
                    end
                end
                phase = HUNT_FIRST;
            end
            default: begin
                phase = (b == hdr_first) ? HUNT_SECOND : HUNT_FIRST;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [sfd_pkg::BYTE_W-1:0] want,
                               input logic [sfd_pkg::BYTE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        payload_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_checked++;
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing expected: index %0d data %0h",
                       m_byte_index, m_payload_byte);
                errors++;
            end else begin
                want = pending_beats.pop_front();
                check_field("pkt_type", want.pkt_type, m_pkt_type);
                check_field("frame_length", 8'(want.frame_length), 8'(m_frame_length));
                check_field("byte_index", 8'(want.byte_index), 8'(m_byte_index));
                check_field("payload_byte", want.payload_byte, m_payload_byte);
                check_field("last_of_frame", 8'(want.last_of_frame), 8'(m_last_of_frame));
            end
        end
    end

    // receiver: long hold-off, random stalls or always ready
    always @(negedge aclk) begin
        int g;
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else if (ready_stall > 0) begin
            m_ready     <= 1'b0;
            ready_stall <= ready_stall - 1;
        end else begin
            g = pick_gap();
            if (g > 0) begin
                ready_stall <= g - 1;
                m_ready     <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
        int gap;
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        parse_rx_byte(b);
        bytes_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_header(input logic [sfd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [sfd_pkg::BYTE_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (idx == sfd_pkg::REG_FIRST_HDR)
            hdr_first = value;
        else
            hdr_second = value;
        header_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input logic [sfd_pkg::BYTE_W-1:0] ftype,
                              input logic [sfd_pkg::BYTE_W-1:0] len_byte,
                              input fill_t fill, input bit bad_sum);
        logic [sfd_pkg::BYTE_W-1:0] sum;
        logic [sfd_pkg::BYTE_W-1:0] d;
        int i;
        send_byte(hdr_first);
        send_byte(hdr_second);
        send_byte(ftype);
        send_byte(len_byte);
        if (len_byte <= 8'(sfd_pkg::MAX_PAYLOAD)) begin
            sum = ftype;
            for (i = 0; i < len_byte; i++) begin
                case (fill)
                    FILL_ONES:  d = 8'hFF;
                    FILL_ZEROS: d = 8'h00;
                    default:    d = 8'($urandom_range(0, 255));
                endcase
                sum = sum + d;
                send_byte(d);
            end
            if (bad_sum)
                send_byte(sum + 8'($urandom_range(1, 255)));
            else
                send_byte(sum);
        end
    endtask

    task automatic send_bad_sync();
        send_byte(hdr_first);
        send_byte(hdr_second ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic test_reset_headers();
        send_frame(8'($urandom_range(0, 255)), 8'd1, FILL_RANDOM, 1'b0);
        send_frame(8'h00, 8'd0, FILL_ZEROS, 1'b0);
    endtask

    task automatic test_field_extremes();
        write_header(sfd_pkg::REG_FIRST_HDR, 8'h00);
        write_header(sfd_pkg::REG_SECOND_HDR, 8'hFF);
        send_frame(8'hFF, 8'(sfd_pkg::MAX_PAYLOAD), FILL_ONES, 1'b0);
        send_frame(8'h00, 8'd1, FILL_ZEROS, 1'b0);
        send_frame(8'h80, 8'd2, FILL_ONES, 1'b0);
        send_frame(8'hFF, 8'd0, FILL_ZEROS, 1'b0);
    endtask

    task automatic test_special_cases();
        send_frame(8'($urandom_range(0, 255)), 8'd3, FILL_RANDOM, 1'b1);
        send_frame(8'($urandom_range(0, 255)), 8'd0, FILL_ZEROS, 1'b1);
        // first header byte in second place is not taken as a new start
        send_byte(hdr_first);
        send_byte(hdr_first);
        send_byte(hdr_second);
        send_frame(8'($urandom_range(0, 255)), 8'd2, FILL_RANDOM, 1'b0);
        send_frame(8'($urandom_range(0, 255)), 8'(sfd_pkg::MAX_PAYLOAD + 1), FILL_RANDOM, 1'b0);
        send_frame(8'($urandom_range(0, 255)), 8'h40, FILL_RANDOM, 1'b0);
        send_frame(8'($urandom_range(0, 255)), 8'hFF, FILL_RANDOM, 1'b0);
        send_bad_sync();
        send_frame(8'($urandom_range(0, 255)), 8'd1, FILL_RANDOM, 1'b0);
        write_header(sfd_pkg::REG_FIRST_HDR, 8'hFF);
        write_header(sfd_pkg::REG_SECOND_HDR, 8'h00);
        send_frame(8'h01, 8'd1, FILL_ONES, 1'b0);
        write_header(sfd_pkg::REG_FIRST_HDR, 8'h5A);
        write_header(sfd_pkg::REG_SECOND_HDR, 8'h5A);
        send_frame(8'($urandom_range(0, 255)), 8'd4, FILL_RANDOM, 1'b0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        steady    = 1'b1;
        hold_left = 400;
        repeat (2) send_frame(8'($urandom_range(0, 255)), 8'd12, FILL_RANDOM, 1'b0);
        wait_idle();
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int first_byte;
        int kind;
        first_byte = bytes_sent;
        steady = 1'b1;
        while (bytes_sent < first_byte + 120) begin
            if (bytes_sent - first_byte > 40)
                steady = 1'b0;
            kind = $urandom_range(0, 99);
            if (kind < 65)
                send_frame(8'($urandom_range(0, 255)), 8'(pick_length()), FILL_RANDOM, 1'b0);
            else if (kind < 75)
                send_frame(8'($urandom_range(0, 255)), 8'(pick_length()), FILL_RANDOM, 1'b1);
            else if (kind < 82)
                send_bad_sync();
            else if (kind < 88)
                send_frame(8'($urandom_range(0, 255)),
                           8'($urandom_range(sfd_pkg::MAX_PAYLOAD + 1, 255)),
                           FILL_RANDOM, 1'b0);
            else
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 39) == 0) begin
                write_header(sfd_pkg::REG_FIRST_HDR, 8'($urandom_range(0, 255)));
                write_header(sfd_pkg::REG_SECOND_HDR, 8'($urandom_range(0, 255)));
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        int waited;
        reset_parser();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_headers();
        test_field_extremes();
        test_special_cases();
        test_backpressure();
        write_header(sfd_pkg::REG_FIRST_HDR, sfd_pkg::FIRST_HDR_RST);
        write_header(sfd_pkg::REG_SECOND_HDR, sfd_pkg::SECOND_HDR_RST);
        test_random_traffic();

        @(negedge aclk);
        s_valid <= 1'b0;
        waited = 0;
        while (pending_beats.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_beats.size() != 0) begin
            $error("%0d expected beats never arrived", pending_beats.size());
            errors++;
        end

        $display("sent %0d bytes over %0d header writes, incl. full-buffer stall",
                 bytes_sent, header_writes);
        $display("%0d frames passed checksum, %0d payload beats checked, %0d mismatches",
                 frames_good, beats_checked, errors);
        if (errors == 0)
            $display("serial_frame_deframer test passed");
        else
            $display("serial_frame_deframer test failed");
        $finish;
    end

endmodule
